>>> hw/rtl/assert_macros.svh
// Assertion macros for the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a plain property on every rising clock edge outside reset.
`define SCS1_ASSERT(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("scs1 assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define SCS1_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scs1 implication failed");

// Check that a condition implies a consequence in the next cycle.
`define SCS1_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scs1 next-cycle check failed");

`else

`define SCS1_ASSERT(lbl, clk, rst_n, expr)
`define SCS1_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SCS1_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/scs1_pkg.sv
// Shared types, constants and key tables of the scan code set 1 decoder.
package scs1_pkg;

  // Special scan codes
  localparam logic [7:0] SC_EXT_PREFIX   = 8'hE0;
  localparam logic [7:0] SC_BREAK_BIT    = 8'h80;
  localparam logic [7:0] SC_ARROW_UP     = 8'h48;
  localparam logic [7:0] SC_ARROW_DOWN   = 8'h50;
  localparam logic [7:0] SC_ARROW_LEFT   = 8'h4B;
  localparam logic [7:0] SC_ARROW_RIGHT  = 8'h4D;
  localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
  localparam logic [7:0] SC_LCTRL_MAKE   = 8'h1D;
  localparam logic [7:0] SC_LCTRL_BREAK  = 8'h9D;
  localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;
  localparam logic [7:0] TABLE_LEN       = 8'd58;

  localparam logic [7:0] CHAR_ETX = 8'h03;

  // Configuration port
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_ARROW_UP    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ARROW_DOWN  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ARROW_LEFT  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ARROW_RIGHT = 3'd3;

  localparam logic [7:0] ARROW_UP_RESET    = 8'd128;
  localparam logic [7:0] ARROW_DOWN_RESET  = 8'd129;
  localparam logic [7:0] ARROW_LEFT_RESET  = 8'd130;
  localparam logic [7:0] ARROW_RIGHT_RESET = 8'd131;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ARROW_UP    = 2'd0,
    ARROW_DOWN  = 2'd1,
    ARROW_LEFT  = 2'd2,
    ARROW_RIGHT = 2'd3
  } arrow_sel_t;

  // One classified key request for the back end
  typedef struct packed {
    logic       is_arrow;
    arrow_sel_t arrow_sel;
    logic [5:0] idx;
    logic       shift;
    logic       caps;
    logic       ctrl;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } fe_req_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  // US layout, unshifted
  function automatic logic [7:0] lower_map(input logic [5:0] idx);
    logic [7:0] c;
    case (idx)
      6'd1:  c = 8'h1B; 6'd2:  c = 8'h31; 6'd3:  c = 8'h32; 6'd4:  c = 8'h33;
      6'd5:  c = 8'h34; 6'd6:  c = 8'h35; 6'd7:  c = 8'h36; 6'd8:  c = 8'h37;
      6'd9:  c = 8'h38; 6'd10: c = 8'h39; 6'd11: c = 8'h30; 6'd12: c = 8'h2D;
      6'd13: c = 8'h3D; 6'd14: c = 8'h08; 6'd15: c = 8'h09; 6'd16: c = 8'h71;
      6'd17: c = 8'h77; 6'd18: c = 8'h65; 6'd19: c = 8'h72; 6'd20: c = 8'h74;
      6'd21: c = 8'h79; 6'd22: c = 8'h75; 6'd23: c = 8'h69; 6'd24: c = 8'h6F;
      6'd25: c = 8'h70; 6'd26: c = 8'h5B; 6'd27: c = 8'h5D; 6'd28: c = 8'h0A;
      6'd30: c = 8'h61; 6'd31: c = 8'h73; 6'd32: c = 8'h64; 6'd33: c = 8'h66;
      6'd34: c = 8'h67; 6'd35: c = 8'h68; 6'd36: c = 8'h6A; 6'd37: c = 8'h6B;
      6'd38: c = 8'h6C; 6'd39: c = 8'h3B; 6'd40: c = 8'h27; 6'd41: c = 8'h60;
      6'd43: c = 8'h5C; 6'd44: c = 8'h7A; 6'd45: c = 8'h78; 6'd46: c = 8'h63;
      6'd47: c = 8'h76; 6'd48: c = 8'h62; 6'd49: c = 8'h6E; 6'd50: c = 8'h6D;
      6'd51: c = 8'h2C; 6'd52: c = 8'h2E; 6'd53: c = 8'h2F; 6'd55: c = 8'h2A;
      6'd57: c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // US layout, shifted
  function automatic logic [7:0] upper_map(input logic [5:0] idx);
    logic [7:0] c;
    case (idx)
      6'd1:  c = 8'h1B; 6'd2:  c = 8'h21; 6'd3:  c = 8'h40; 6'd4:  c = 8'h23;
      6'd5:  c = 8'h24; 6'd6:  c = 8'h25; 6'd7:  c = 8'h5E; 6'd8:  c = 8'h26;
      6'd9:  c = 8'h2A; 6'd10: c = 8'h28; 6'd11: c = 8'h29; 6'd12: c = 8'h5F;
      6'd13: c = 8'h2B; 6'd14: c = 8'h08; 6'd15: c = 8'h09; 6'd16: c = 8'h51;
      6'd17: c = 8'h57; 6'd18: c = 8'h45; 6'd19: c = 8'h52; 6'd20: c = 8'h54;
      6'd21: c = 8'h59; 6'd22: c = 8'h55; 6'd23: c = 8'h49; 6'd24: c = 8'h4F;
      6'd25: c = 8'h50; 6'd26: c = 8'h7B; 6'd27: c = 8'h7D; 6'd28: c = 8'h0A;
      6'd30: c = 8'h41; 6'd31: c = 8'h53; 6'd32: c = 8'h44; 6'd33: c = 8'h46;
      6'd34: c = 8'h47; 6'd35: c = 8'h48; 6'd36: c = 8'h4A; 6'd37: c = 8'h4B;
      6'd38: c = 8'h4C; 6'd39: c = 8'h3A; 6'd40: c = 8'h22; 6'd41: c = 8'h7E;
      6'd43: c = 8'h7C; 6'd44: c = 8'h5A; 6'd45: c = 8'h58; 6'd46: c = 8'h43;
      6'd47: c = 8'h56; 6'd48: c = 8'h42; 6'd49: c = 8'h4E; 6'd50: c = 8'h4D;
      6'd51: c = 8'h3C; 6'd52: c = 8'h3E; 6'd53: c = 8'h3F; 6'd55: c = 8'h2A;
      6'd57: c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> hw/rtl/scs1_queue.sv
// Two-entry request queue between the decoder front and back ends.
`include "assert_macros.svh"

module scs1_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  scs1_pkg::fe_req_t req,
  output logic              full,
  output scs1_pkg::q_head_t head,
  input  logic              pop
);
  import scs1_pkg::*;

  cmd_t                   mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] count_r, count_nxt;
  logic                   do_push;
  logic                   do_pop;

  assign full       = (count_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.cmd   = mem_r[rd_ptr_r];

  assign do_push = req.push && !full;
  assign do_pop  = pop && head.valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the request payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= req.cmd;
    end
  end

  `SCS1_ASSERT(a_count_bound, clk, rst_n, count_r <= QUEUE_CNT_W'(QUEUE_DEPTH))
  `SCS1_ASSERT_IMP(a_no_overflow, clk, rst_n, req.push, !full)
  `SCS1_ASSERT_NXT(a_count_up, clk, rst_n, do_push && !do_pop,
                   count_r == $past(count_r) + 1'b1)
  `SCS1_ASSERT_NXT(a_count_down, clk, rst_n, do_pop && !do_push,
                   count_r == $past(count_r) - 1'b1)

endmodule

>>> hw/rtl/scs1_front.sv
// Front end: accepts scan bytes, tracks prefix and modifiers, classifies keys.
module scs1_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_scan_byte,
  input  logic              q_full,
  output scs1_pkg::fe_req_t req
);
  import scs1_pkg::*;

  logic ext_r, ext_nxt;
  logic shift_r, shift_nxt;
  logic ctrl_r, ctrl_nxt;
  logic caps_r, caps_nxt;
  logic accept;
  logic want_push;
  logic is_arrow;
  arrow_sel_t arrow_sel;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Classify the byte and work out the next modifier state
  always_comb begin
    ext_nxt   = ext_r;
    shift_nxt = shift_r;
    ctrl_nxt  = ctrl_r;
    caps_nxt  = caps_r;
    want_push = 1'b0;
    is_arrow  = 1'b0;
    arrow_sel = ARROW_UP;
    if (in_scan_byte == SC_EXT_PREFIX) begin
      ext_nxt = 1'b1;
    end else if (ext_r) begin
      // Extended byte: only arrow makes go on, modifiers are ignored
      ext_nxt  = 1'b0;
      is_arrow = 1'b1;
      case (in_scan_byte)
        SC_ARROW_UP: begin
          want_push = 1'b1;
          arrow_sel = ARROW_UP;
        end
        SC_ARROW_DOWN: begin
          want_push = 1'b1;
          arrow_sel = ARROW_DOWN;
        end
        SC_ARROW_LEFT: begin
          want_push = 1'b1;
          arrow_sel = ARROW_LEFT;
        end
        SC_ARROW_RIGHT: begin
          want_push = 1'b1;
          arrow_sel = ARROW_RIGHT;
        end
        default: want_push = 1'b0;
      endcase
    end else begin
      case (in_scan_byte) inside
        SC_LSHIFT_MAKE, SC_RSHIFT_MAKE:   shift_nxt = 1'b1;
        SC_LSHIFT_BREAK, SC_RSHIFT_BREAK: shift_nxt = 1'b0;
        SC_LCTRL_MAKE:                    ctrl_nxt  = 1'b1;
        SC_LCTRL_BREAK:                   ctrl_nxt  = 1'b0;
        SC_CAPS_MAKE:                     caps_nxt  = !caps_r;
        default: begin
          want_push = ((in_scan_byte & SC_BREAK_BIT) == 8'h00) &&
                      (in_scan_byte < TABLE_LEN);
        end
      endcase
    end
  end

  // Drive the request to the queue
  assign req.push          = accept && want_push;
  assign req.cmd.is_arrow  = is_arrow;
  assign req.cmd.arrow_sel = arrow_sel;
  assign req.cmd.idx       = in_scan_byte[5:0];
  assign req.cmd.shift     = shift_r;
  assign req.cmd.caps      = caps_r;
  assign req.cmd.ctrl      = ctrl_r;

  // Update state only on an accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_r   <= 1'b0;
      shift_r <= 1'b0;
      ctrl_r  <= 1'b0;
      caps_r  <= 1'b0;
    end else if (accept) begin
      ext_r   <= ext_nxt;
      shift_r <= shift_nxt;
      ctrl_r  <= ctrl_nxt;
      caps_r  <= caps_nxt;
    end
  end

endmodule

>>> hw/rtl/scs1_back.sv
// Back end: arrow code registers, key table lookup and the output register.
module scs1_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [scs1_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [scs1_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  scs1_pkg::q_head_t                    head,
  output logic                                 pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [7:0]                           out_character
);
  import scs1_pkg::*;

  logic [7:0] arrow_code_r [4];
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r;
  logic [7:0] lo_c;
  logic [7:0] up_c;
  logic [7:0] key_c;
  logic [7:0] char_c;
  logic       out_free;

  // Hold the arrow codes; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arrow_code_r[0] <= ARROW_UP_RESET;
      arrow_code_r[1] <= ARROW_DOWN_RESET;
      arrow_code_r[2] <= ARROW_LEFT_RESET;
      arrow_code_r[3] <= ARROW_RIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ARROW_UP:    arrow_code_r[0] <= cfg_wdata[7:0];
        CFG_ARROW_DOWN:  arrow_code_r[1] <= cfg_wdata[7:0];
        CFG_ARROW_LEFT:  arrow_code_r[2] <= cfg_wdata[7:0];
        CFG_ARROW_RIGHT: arrow_code_r[3] <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Look up the character or arrow code, apply caps lock to letters and ctrl-C
  always_comb begin
    lo_c = lower_map(head.cmd.idx);
    up_c = upper_map(head.cmd.idx);
    if (head.cmd.shift) begin
      key_c = (head.cmd.caps && (up_c inside {[8'h41:8'h5A]})) ? lo_c : up_c;
    end else begin
      key_c = (head.cmd.caps && (lo_c inside {[8'h61:8'h7A]})) ? up_c : lo_c;
    end
    if (head.cmd.ctrl && (key_c == 8'h63 || key_c == 8'h43)) begin
      key_c = CHAR_ETX;
    end
    char_c = head.cmd.is_arrow ? arrow_code_r[head.cmd.arrow_sel] : key_c;
  end

  // Advance the queue when the output register is free; drop zero results
  assign out_free = !out_valid_r || out_ready;
  assign pop      = head.valid && out_free;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = (char_c != 8'h00);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_char_r <= char_c;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;

endmodule

>>> hw/rtl/scancode_set1_to_ascii_decoder_unit.sv
// Top level of the scan code set 1 to ASCII decoder (US layout).
//
// Takes one scan code set 1 byte per request on the in_ channel and gives at most one
// character on the out_ channel, in order. A new byte is accepted every clock cycle
// while the two-entry queue between the front end and the back end has room; a
// character moves from the queue head into the output register once that register is
// free or being emptied, and is then offered on the out_ channel. Prefix, modifier,
// break and out-of-table bytes are consumed by the front end and give no request;
// table codes with no character are dropped by the back end. The four arrow codes sit
// at configuration indexes 0 to 3 (up, down, left, right); a code of zero suppresses
// that arrow; other indexes ignore writes. Write them only while the decoder is idle.
module scancode_set1_to_ascii_decoder_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_scan_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_character,
  input  logic                             cfg_we,
  input  logic [scs1_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [scs1_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import scs1_pkg::*;

  fe_req_t fe_req;
  q_head_t q_head;
  logic    q_full;
  logic    q_pop;

  scs1_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_scan_byte (in_scan_byte),
    .q_full       (q_full),
    .req          (fe_req)
  );

  scs1_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (fe_req),
    .full  (q_full),
    .head  (q_head),
    .pop   (q_pop)
  );

  scs1_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .head          (q_head),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character)
  );

endmodule

>>> tb/sv/scs1_char_check_pkg.sv
// Character scoreboard with its own key decode state for the scan code decoder bench.
package scs1_char_check_pkg;
  import scs1_pkg::*;

  class char_scoreboard;
    // US layout indexed by make code: unshifted, then with shift held
    logic [7:0] plain_keys [58] = '{
      8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
      8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
      8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
      8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
      8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
      8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20
    };
    logic [7:0] shifted_keys [58] = '{
      8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
      8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
      8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
      8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
      8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
      8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20
    };
    logic [7:0]  arrow_code [4];
    bit          prefix_seen;
    bit          shift_down;
    bit          ctrl_down;
    bit          caps_on;
    logic [7:0]  due_chars [$];
    int unsigned error_count;

    function new();
      arrow_code[ARROW_UP]    = ARROW_UP_RESET;
      arrow_code[ARROW_DOWN]  = ARROW_DOWN_RESET;
      arrow_code[ARROW_LEFT]  = ARROW_LEFT_RESET;
      arrow_code[ARROW_RIGHT] = ARROW_RIGHT_RESET;
    endfunction

    // Mirror a register write; unused indexes change nothing
    function void write_arrow(input logic [CFG_INDEX_W-1:0] index, input logic [7:0] value);
      if (index <= CFG_ARROW_RIGHT) arrow_code[index[1:0]] = value;
    endfunction

    // Advance the key state by one accepted request and queue any character it gives
    function void note_scan(input logic [7:0] sc);
      logic [7:0] ch;
      ch = 8'h00;
      if (sc == SC_EXT_PREFIX) begin
        prefix_seen = 1'b1;
        return;
      end
      if (prefix_seen) begin
        // Byte after the prefix: only arrow makes count, modifiers are ignored
        prefix_seen = 1'b0;
        case (sc)
          SC_ARROW_UP:    ch = arrow_code[ARROW_UP];
          SC_ARROW_DOWN:  ch = arrow_code[ARROW_DOWN];
          SC_ARROW_LEFT:  ch = arrow_code[ARROW_LEFT];
          SC_ARROW_RIGHT: ch = arrow_code[ARROW_RIGHT];
          default:        ch = 8'h00;
        endcase
      end else begin
        case (sc)
          SC_LSHIFT_MAKE, SC_RSHIFT_MAKE:   shift_down = 1'b1;
          SC_LSHIFT_BREAK, SC_RSHIFT_BREAK: shift_down = 1'b0;
          SC_LCTRL_MAKE:                    ctrl_down = 1'b1;
          SC_LCTRL_BREAK:                   ctrl_down = 1'b0;
          SC_CAPS_MAKE:                     caps_on = !caps_on;
          default: begin
            // Breaks and codes past the table give nothing
            if (sc < TABLE_LEN) begin
              // Caps lock flips the case of letters only
              if (shift_down) begin
                ch = shifted_keys[sc[5:0]];
                if (caps_on && ch >= "A" && ch <= "Z") ch = plain_keys[sc[5:0]];
              end else begin
                ch = plain_keys[sc[5:0]];
                if (caps_on && ch >= "a" && ch <= "z") ch = shifted_keys[sc[5:0]];
              end
              if (ctrl_down && (ch == "c" || ch == "C")) ch = CHAR_ETX;
            end
          end
        endcase
      end
      if (ch != 8'h00) due_chars.push_back(ch);
    endfunction

    // Compare one delivered character with the oldest one due
    task check_char(input logic [7:0] got);
      logic [7:0] want;
      if (due_chars.size() == 0) begin
        report($sformatf("unexpected character 8'h%02h", got));
        return;
      end
      want = due_chars.pop_front();
      if (got !== want) report($sformatf("character 8'h%02h, wanted 8'h%02h", got, want));
    endtask

    task report(input string what);
      $display("[%0t] MISMATCH %s", $time, what);
      error_count++;
    endtask
  endclass

endpackage

>>> tb/sv/scancode_set1_to_ascii_decoder_unit_test.sv
// Top-level bench for the scan code set 1 to ASCII decoder: stimulus, handshakes, watchdog.
module scancode_set1_to_ascii_decoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import scs1_pkg::*;
  import scs1_char_check_pkg::*;

  localparam int unsigned PHASE_ITEMS  = 160;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned QUIET_LIMIT  = 2000;

  // Plain keys used by the directed walk
  localparam logic [7:0] KEY_NONE = 8'h00;
  localparam logic [7:0] KEY_ESC  = 8'h01;
  localparam logic [7:0] KEY_1    = 8'h02;
  localparam logic [7:0] KEY_Q    = 8'h10;
  localparam logic [7:0] KEY_C    = 8'h2E;
  localparam logic [7:0] KEY_F1   = 8'h3B;
  localparam logic [7:0] KEY_TOP  = 8'h7F;

  logic                   clk          = 1'b0;
  logic                   rst_n        = 1'b0;
  logic                   in_valid     = 1'b0;
  logic                   in_ready;
  logic [7:0]             in_scan_byte = 8'h00;
  logic                   out_valid;
  logic                   out_ready    = 1'b0;
  logic [7:0]             out_character;
  logic                   cfg_we       = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = CFG_ARROW_UP;
  logic [CFG_DATA_W-1:0]  cfg_wdata    = 8'h00;

  int unsigned    send_idle_pct  = 0;
  int unsigned    recv_stall_pct = 0;
  int unsigned    scans_sent     = 0;
  int unsigned    quiet_cycles   = 0;
  char_scoreboard sb             = new();

  scancode_set1_to_ascii_decoder_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_scan_byte  (in_scan_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result side at random
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check every delivered character
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_char(out_character);
  end

  // Give up when no request moves on either side for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one scan byte, idling first at random, and hold it until accepted
  task automatic send_scan(input logic [7:0] sc);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_scan_byte <= sc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_scan(sc);
    scans_sent++;
  endtask

  // Drop valid and wait until every due character is out and the pipe is empty
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.due_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [7:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_arrow(index, value);
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1:       begin send_idle_pct = 73; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 73; end
      default: begin send_idle_pct = 12; recv_stall_pct = 12; end
    endcase
  endtask

  initial begin
    logic [7:0]  walk [$];
    logic [7:0]  arrow;
    logic [7:0]  value;
    int unsigned pick;
    int unsigned phase_end;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed walk at reset arrow codes: table edges, modifiers, caps, ctrl-C, prefixes
    walk = '{KEY_NONE, KEY_ESC, KEY_Q, SC_CAPS_MAKE, KEY_Q, KEY_1, SC_LSHIFT_MAKE, KEY_Q,
             KEY_1, SC_LSHIFT_BREAK, SC_CAPS_MAKE, SC_LCTRL_MAKE, KEY_C, SC_LCTRL_BREAK,
             KEY_F1, KEY_TOP, SC_CAPS_MAKE | SC_BREAK_BIT, SC_EXT_PREFIX, SC_EXT_PREFIX,
             SC_ARROW_UP, SC_EXT_PREFIX, SC_ARROW_DOWN, SC_EXT_PREFIX, SC_ARROW_LEFT,
             SC_EXT_PREFIX, SC_ARROW_RIGHT, SC_EXT_PREFIX, SC_LCTRL_MAKE, KEY_C,
             SC_EXT_PREFIX, SC_ARROW_UP | SC_BREAK_BIT};
    foreach (walk[k]) send_scan(walk[k]);
    settle();

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      // Reprogram all arrow codes plus the unused indexes: zeros, all ones, then random
      for (int r = int'(CFG_ARROW_UP); r < (1 << CFG_INDEX_W); r++) begin
        if (ph == 0) begin
          value = 8'h00;
        end else if (ph == 1) begin
          value = 8'hFF;
        end else begin
          value = ($urandom_range(5) == 0) ? 8'h00 : 8'($urandom_range(255));
        end
        write_reg(CFG_INDEX_W'(r), value);
      end
      @(negedge clk);
      cfg_we <= 1'b0;
      set_idling(ph % 4);

      // Mostly plausible key traffic, some prefix junk and raw noise
      phase_end = scans_sent + PHASE_ITEMS;
      while (scans_sent < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          send_scan(8'($urandom_range(int'(TABLE_LEN) - 1)));
        end else if (pick < 50) begin
          send_scan(SC_BREAK_BIT | 8'($urandom_range(int'(TABLE_LEN) - 1)));
        end else if (pick < 58) begin
          case ($urandom_range(3))
            0:       send_scan(SC_LSHIFT_MAKE);
            1:       send_scan(SC_RSHIFT_MAKE);
            2:       send_scan(SC_LSHIFT_BREAK);
            default: send_scan(SC_RSHIFT_BREAK);
          endcase
        end else if (pick < 64) begin
          send_scan($urandom_range(1) ? SC_LCTRL_MAKE : SC_LCTRL_BREAK);
        end else if (pick < 68) begin
          send_scan($urandom_range(1) ? SC_CAPS_MAKE : (SC_CAPS_MAKE | SC_BREAK_BIT));
        end else if (pick < 82) begin
          case ($urandom_range(3))
            0:       arrow = SC_ARROW_UP;
            1:       arrow = SC_ARROW_DOWN;
            2:       arrow = SC_ARROW_LEFT;
            default: arrow = SC_ARROW_RIGHT;
          endcase
          if ($urandom_range(3) == 0) arrow = arrow | SC_BREAK_BIT;
          send_scan(SC_EXT_PREFIX);
          send_scan(arrow);
        end else if (pick < 90) begin
          send_scan(SC_EXT_PREFIX);
          send_scan(8'($urandom_range(255)));
        end else if (pick < 94) begin
          send_scan(SC_EXT_PREFIX);
        end else begin
          send_scan(8'($urandom_range(255)));
        end
      end
      settle();
    end

    if (sb.error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/scs1_pkg.sv
hw/rtl/scs1_queue.sv
hw/rtl/scs1_front.sv
hw/rtl/scs1_back.sv
hw/rtl/scancode_set1_to_ascii_decoder_unit.sv
tb/sv/scs1_char_check_pkg.sv
tb/sv/scancode_set1_to_ascii_decoder_unit_test.sv
